// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the pose transform.
// Expects signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while in reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/etwp_pkg.sv -----
// Package for the ego-to-world pose transform: widths, CORDIC constants, types.
// No dependencies.
`default_nettype none

package etwp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int POS_BITS      = 24;
	localparam int HEAD_BITS     = 16;
	localparam int ANG_BITS      = 32;
	localparam int FRAC_BITS     = 30;
	localparam int ATAN_LEN      = 24;

	localparam int PROD_BITS = ANG_BITS + POS_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int RND_BITS  = SUM_BITS - FRAC_BITS;
	localparam int WIDE_BITS = RND_BITS + 1;

	// pipeline stage indices
	localparam int ST_FLIP = CORDIC_STAGES + 1;
	localparam int ST_MUL  = CORDIC_STAGES + 2;
	localparam int ST_SUM  = CORDIC_STAGES + 3;
	localparam int ST_OUT  = CORDIC_STAGES + 4;
	localparam int NUM_ST  = ST_OUT + 1;

	typedef logic signed [POS_BITS-1:0]  pos_t;
	typedef logic        [HEAD_BITS-1:0] head_t;
	typedef logic signed [ANG_BITS-1:0]  ang_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [WIDE_BITS-1:0] wide_t;

	localparam ang_t GAIN_Q30 = 32'sd652032874;

	localparam logic [ANG_BITS-1:0] ATAN_TAB [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(64'sd1 <<< (FRAC_BITS - 1));
	localparam wide_t POS_MAX_W = WIDE_BITS'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
	localparam wide_t POS_MIN_W = WIDE_BITS'(-(64'sd1 <<< (POS_BITS - 1)));

	// payload riding along the CORDIC stages
	typedef struct packed {
		pos_t  rel_x;
		pos_t  rel_y;
		pos_t  robot_x;
		pos_t  robot_y;
		head_t heading;
		logic  flip;
	} carry_t;

	// payload after the rotation products are taken
	typedef struct packed {
		pos_t  robot_x;
		pos_t  robot_y;
		head_t heading;
	} tail_t;

endpackage

`default_nettype wire

// ----- sv/etwp_in_if.sv -----
// Input channel of the pose transform: valid/ready plus one pose beat.
// Depends on etwp_pkg.
`default_nettype none

interface etwp_in_if import etwp_pkg::*; ();
	logic  valid;
	logic  ready;
	pos_t  rel_x;
	pos_t  rel_y;
	head_t rel_heading;
	pos_t  robot_x;
	pos_t  robot_y;
	head_t robot_heading;

	modport source (output valid, rel_x, rel_y, rel_heading, robot_x, robot_y,
		robot_heading, input ready);
	modport sink (input valid, rel_x, rel_y, rel_heading, robot_x, robot_y,
		robot_heading, output ready);
endinterface

`default_nettype wire

// ----- sv/etwp_out_if.sv -----
// Output channel of the pose transform: valid/ready plus one world pose beat.
// Depends on etwp_pkg.
`default_nettype none

interface etwp_out_if import etwp_pkg::*; ();
	logic  valid;
	logic  ready;
	pos_t  world_x;
	pos_t  world_y;
	head_t world_heading;
	logic  saturated;

	modport source (output valid, world_x, world_y, world_heading, saturated,
		input ready);
	modport sink (input valid, world_x, world_y, world_heading, saturated,
		output ready);
endinterface

`default_nettype wire

// ----- sv/ego_to_world_pose_transform.sv -----
// Ego-to-world pose transform: CORDIC rotation pipeline, rounding and saturation.
// Depends on etwp_pkg, etwp_in_if, etwp_out_if and assert_macros.svh.
//
// Usage:
//   item   - sink channel; one beat holds a robot-relative pose (rel_x, rel_y,
//            rel_heading) and the robot's world pose (robot_x, robot_y, robot_heading).
//   result - source channel; one beat per item with world_x, world_y (saturated mm),
//            world_heading (sum of headings, wraps) and saturated.
// Pipeline: 21 registers from the accepting edge to result.valid: fold, one register
//   per CORDIC iteration, sign fix, products, round/offset add, saturate.
// Throughput: one beat per cycle while not stalled; the pipeline is fully unrolled.
// Stall: all stages advance together while the output register is empty or
//   being taken; bubbles stay where they are, and item.ready only drops when
//   the output register holds a beat that result.ready refuses.
// Reset: arst_n clears all valid bits; no beat is in flight afterwards.
`default_nettype none
`include "assert_macros.svh"

module ego_to_world_pose_transform import etwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	etwp_in_if.sink    item,
	etwp_out_if.source result
);

	logic              adv;
	logic [NUM_ST-1:0] v_s;

	// CORDIC stage registers: index 0 is the folded input
	ang_t   cx_s [CORDIC_STAGES+1];
	ang_t   cy_s [CORDIC_STAGES+1];
	ang_t   cz_s [CORDIC_STAGES];
	carry_t cr_s [CORDIC_STAGES+1];

	ang_t  cos_s, sin_s;
	carry_t fl_s;
	prod_t pcx_s, psy_s, psx_s, pcy_s;
	tail_t mul_s;
	wide_t wx_s, wy_s;
	tail_t sum_s;
	pos_t  out_x_s, out_y_s;
	head_t out_h_s;
	logic  out_sat_s;

	logic  flip_in;
	head_t zhead;
	logic signed [SUM_BITS-1:0] sum_x, sum_y;
	logic  clip_x_hi, clip_x_lo, clip_y_hi, clip_y_lo;
	logic  sat_on_rail;

	// whole pipe moves when the output slot is free or being drained
	assign adv        = !v_s[ST_OUT] || result.ready;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NUM_ST-2:0], item.valid};
		end
	end

	// Quadrant fold: headings in [90,270) deg move by half a turn, result negated.
	// Bits 15 and 14 differ exactly there; half a turn is a flip of the top bit.
	assign flip_in = item.robot_heading[HEAD_BITS-1] ^ item.robot_heading[HEAD_BITS-2];
	assign zhead   = flip_in ? (item.robot_heading ^ {1'b1, {(HEAD_BITS-1){1'b0}}})
		: item.robot_heading;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0]         <= GAIN_Q30;
			cy_s[0]         <= '0;
			cz_s[0]         <= {zhead, {(ANG_BITS-HEAD_BITS){1'b0}}};
			cr_s[0].rel_x   <= item.rel_x;
			cr_s[0].rel_y   <= item.rel_y;
			cr_s[0].robot_x <= item.robot_x;
			cr_s[0].robot_y <= item.robot_y;
			cr_s[0].heading <= item.rel_heading + item.robot_heading;
			cr_s[0].flip    <= flip_in;
		end
	end

	// One micro-rotation per register stage; z >= 0 rotates positive.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				cr_s[i+1] <= cr_s[i];
				if (!cz_s[i][ANG_BITS-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				end
			end
		end
		// last angle residue is never needed
		if (i < CORDIC_STAGES - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!cz_s[i][ANG_BITS-1]) begin
						cz_s[i+1] <= cz_s[i] - $signed(ATAN_TAB[i]);
					end else begin
						cz_s[i+1] <= cz_s[i] + $signed(ATAN_TAB[i]);
					end
				end
			end
		end
	end

	// undo the quadrant fold
	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s <= cr_s[CORDIC_STAGES].flip ? -cx_s[CORDIC_STAGES] : cx_s[CORDIC_STAGES];
			sin_s <= cr_s[CORDIC_STAGES].flip ? -cy_s[CORDIC_STAGES] : cy_s[CORDIC_STAGES];
			fl_s  <= cr_s[CORDIC_STAGES];
		end
	end

	// rotation products, Q30 times millimetres
	always_ff @(posedge clk) begin
		if (adv) begin
			pcx_s         <= PROD_BITS'(cos_s) * PROD_BITS'(fl_s.rel_x);
			psy_s         <= PROD_BITS'(sin_s) * PROD_BITS'(fl_s.rel_y);
			psx_s         <= PROD_BITS'(sin_s) * PROD_BITS'(fl_s.rel_x);
			pcy_s         <= PROD_BITS'(cos_s) * PROD_BITS'(fl_s.rel_y);
			mul_s.robot_x <= fl_s.robot_x;
			mul_s.robot_y <= fl_s.robot_y;
			mul_s.heading <= fl_s.heading;
		end
	end

	// round half up out of Q30, then offset by the robot position
	assign sum_x = SUM_BITS'(pcx_s) - SUM_BITS'(psy_s) + ROUND_HALF;
	assign sum_y = SUM_BITS'(psx_s) + SUM_BITS'(pcy_s) + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s  <= WIDE_BITS'(sum_x >>> FRAC_BITS) + WIDE_BITS'(mul_s.robot_x);
			wy_s  <= WIDE_BITS'(sum_y >>> FRAC_BITS) + WIDE_BITS'(mul_s.robot_y);
			sum_s <= mul_s;
		end
	end

	// clip to the position range
	assign clip_x_hi = wx_s > POS_MAX_W;
	assign clip_x_lo = wx_s < POS_MIN_W;
	assign clip_y_hi = wy_s > POS_MAX_W;
	assign clip_y_lo = wy_s < POS_MIN_W;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_s   <= clip_x_hi ? POS_BITS'(POS_MAX_W)
				: (clip_x_lo ? POS_BITS'(POS_MIN_W) : POS_BITS'(wx_s));
			out_y_s   <= clip_y_hi ? POS_BITS'(POS_MAX_W)
				: (clip_y_lo ? POS_BITS'(POS_MIN_W) : POS_BITS'(wy_s));
			out_h_s   <= sum_s.heading;
			out_sat_s <= clip_x_hi || clip_x_lo || clip_y_hi || clip_y_lo;
		end
	end

	assign result.valid         = v_s[ST_OUT];
	assign result.world_x       = out_x_s;
	assign result.world_y       = out_y_s;
	assign result.world_heading = out_h_s;
	assign result.saturated     = out_sat_s;

	// some output coordinate sits on a rail
	assign sat_on_rail = result.world_x == POS_BITS'(POS_MAX_W)
		|| result.world_x == POS_BITS'(POS_MIN_W)
		|| result.world_y == POS_BITS'(POS_MAX_W)
		|| result.world_y == POS_BITS'(POS_MIN_W);

	// accepted beat lands in the first stage
	`ASSERT_NEXT(a_accept_enters, item.valid && item.ready, v_s[0], "accepted beat lost at entry")
	// stalled output freezes the whole pipe
	`ASSERT_NEXT(a_stall_holds, result.valid && !result.ready, $stable(v_s), "pipe moved in stall")
	// saturated flag only with a clipped coordinate
	`ASSERT_CLK(a_sat_extreme, !(result.valid && result.saturated) || sat_on_rail, "sat off rail")

endmodule

`default_nettype wire

// ----- verif/etwp_pose_checker.sv -----
`timescale 1ns / 100ps
// Pose checker: watches the item and result channels, predicts each world pose and compares.
// Depends on etwp_pkg, etwp_in_if and etwp_out_if.

module etwp_pose_checker import etwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	etwp_in_if         item,
	etwp_out_if        result,
	output int         mismatches,
	output int         outstanding,
	output int         poses_checked,
	output int         clipped_seen
);

	typedef struct packed {
		pos_t  x;
		pos_t  y;
		head_t heading;
		logic  clipped;
	} world_pose_t;

	localparam int     ROT_STEPS  = 16;
	localparam longint GAIN_Q30   = 64'sd652032874;
	localparam longint QUARTER    = 64'sd1 <<< 30;
	localparam longint HALF_TURN  = 64'sd1 <<< 31;
	localparam longint FULL_TURN  = 64'sd1 <<< 32;
	localparam longint ROUND_HALF = 64'sd1 <<< 29;
	localparam longint POS_HI     = (64'sd1 <<< 23) - 64'sd1;
	localparam longint POS_LO     = -(64'sd1 <<< 23);

	// arctan(2^-i), full turn = 2^32
	localparam longint ATAN_STEP [24] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
		'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
		'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
		'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
		'h0000028C, 'h00000146, 'h000000A3, 'h00000051
	};

	world_pose_t expected_poses [$];
	int fail_count = 0;
	int checked    = 0;
	int clipped    = 0;

	function automatic longint clip_pos(longint v, ref logic clipped_flag);
		if (v > POS_HI) begin
			clipped_flag = 1'b1;
			return POS_HI;
		end
		if (v < POS_LO) begin
			clipped_flag = 1'b1;
			return POS_LO;
		end
		return v;
	endfunction

	function automatic world_pose_t world_pose_of(pos_t rel_x, pos_t rel_y, head_t rel_h,
			pos_t bot_x, pos_t bot_y, head_t bot_h);
		longint ang, cx, sy, dx, dy, sum_x, sum_y;
		bit mirrored;
		logic clipped_flag;
		world_pose_t p;
		ang = 0;
		ang[31:16] = bot_h;
		if (ang >= HALF_TURN)
			ang -= FULL_TURN;
		// fold the rear half-plane onto the front one, negate at the end
		mirrored = (ang >= QUARTER) || (ang < -QUARTER);
		if (mirrored)
			ang = (ang >= 0) ? ang - HALF_TURN : ang + HALF_TURN;
		cx = GAIN_Q30;
		sy = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = sy >>> i;
			dy = cx >>> i;
			if (ang >= 0) begin
				cx -= dx;
				sy += dy;
				ang -= ATAN_STEP[i];
			end else begin
				cx += dx;
				sy -= dy;
				ang += ATAN_STEP[i];
			end
		end
		if (mirrored) begin
			cx = -cx;
			sy = -sy;
		end
		sum_x = ((cx * longint'(rel_x) - sy * longint'(rel_y) + ROUND_HALF) >>> 30)
			+ longint'(bot_x);
		sum_y = ((sy * longint'(rel_x) + cx * longint'(rel_y) + ROUND_HALF) >>> 30)
			+ longint'(bot_y);
		clipped_flag = 1'b0;
		p.x       = pos_t'(clip_pos(sum_x, clipped_flag));
		p.y       = pos_t'(clip_pos(sum_y, clipped_flag));
		p.heading = rel_h + bot_h;
		p.clipped = clipped_flag;
		return p;
	endfunction

	task automatic compare_field(string field, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Result side first: with a pipeline behind it, a result beat never
	// belongs to an item beat taken on the same edge.
	always @(posedge clk) begin
		world_pose_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_poses.size() == 0) begin
					$display("%0t: result beat with nothing expected, got x %0d y %0d h %0d s %0b",
						$time, result.world_x, result.world_y, result.world_heading,
						result.saturated);
					fail_count++;
				end else begin
					want = expected_poses.pop_front();
					compare_field("world_x", want.x, result.world_x);
					compare_field("world_y", want.y, result.world_y);
					compare_field("world_heading", {16'd0, want.heading}, {16'd0, result.world_heading});
					compare_field("saturated", {31'd0, want.clipped}, {31'd0, result.saturated});
					checked++;
					if (want.clipped)
						clipped++;
				end
			end
			if (item.valid && item.ready)
				expected_poses.push_back(world_pose_of(item.rel_x, item.rel_y, item.rel_heading,
					item.robot_x, item.robot_y, item.robot_heading));
		end
		mismatches    <= fail_count;
		outstanding   <= expected_poses.size();
		poses_checked <= checked;
		clipped_seen  <= clipped;
	end

endmodule

// ----- verif/tb_ego_to_world_pose_transform.sv -----
`timescale 1ns / 100ps
// Top of the pose transform testbench: clock, reset, pose stimulus, ready pattern, verdict.
// Depends on etwp_pkg, etwp_in_if, etwp_out_if, etwp_pose_checker and the block itself.

module tb_ego_to_world_pose_transform;
	import etwp_pkg::*;

	localparam int RANDOM_POSES = 1730;
	localparam int PHASE_POSES  = RANDOM_POSES / 3;
	// Drain time before the verdict, well beyond the pipeline latency.
	localparam int DRAIN_CYCLES = 45;
	// Quiet cycles (no beat on either channel) tolerated before giving up.
	localparam int QUIET_LIMIT  = 1000;

	localparam pos_t  POS_MAX = {1'b0, {23{1'b1}}};
	localparam pos_t  POS_MIN = {1'b1, 23'd0};
	localparam head_t DEG_45  = 16'h2000;
	localparam head_t DEG_90  = 16'h4000;
	localparam head_t DEG_180 = 16'h8000;
	localparam head_t DEG_270 = 16'hC000;

	bit   clk = 1'b0;
	logic arst_n;

	etwp_in_if  item ();
	etwp_out_if result ();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int poses_sent    = 0;
	int directed_sent = 0;
	int quiet_cycles  = 0;

	int mismatches, outstanding, poses_checked, clipped_seen;

	ego_to_world_pose_transform dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	etwp_pose_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.result        (result),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.poses_checked (poses_checked),
		.clipped_seen  (clipped_seen)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: refuses a beat at random, at the rate of the current phase.
	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a hung pipeline or a lost result shows up as a long silence.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles, giving up", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Offers one pose beat. Called on a rising edge; returns on the edge that
	// takes the beat, so the caller can drive the next one straight away.
	// Ready is read before the edge's updates land, i.e. the value that decided it.
	task automatic send_pose(pos_t rel_x, pos_t rel_y, head_t rel_h,
			pos_t bot_x, pos_t bot_y, head_t bot_h);
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid         <= 1'b1;
		item.rel_x         <= rel_x;
		item.rel_y         <= rel_y;
		item.rel_heading   <= rel_h;
		item.robot_x       <= bot_x;
		item.robot_y       <= bot_y;
		item.robot_heading <= bot_h;
		do
			@(posedge clk);
		while (!item.ready);
		poses_sent++;
	endtask

	// Sender goes quiet until every outstanding pose has come back.
	task automatic hold_until_drained();
		item.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Positions: rails, a band around zero where rotation is easy to follow,
	// and the full range so every bit toggles.
	function automatic pos_t pick_pos();
		int near;
		near = $urandom_range(2000);
		case ($urandom_range(7))
			0: return POS_MAX;
			1: return POS_MIN;
			2, 3: return pos_t'(near - 1000);
			default: return pos_t'($urandom);
		endcase
	endfunction

	// Headings: mostly anywhere, now and then on or next to a quadrant edge; at 90
	// and 270 deg the fold into the front half-plane switches.
	function automatic head_t pick_heading();
		head_t quadrant;
		quadrant = head_t'($urandom_range(3)) << 14;
		case ($urandom_range(5))
			0: return quadrant;
			1: return quadrant - 16'd1;
			2: return quadrant + 16'd1;
			default: return head_t'($urandom);
		endcase
	endfunction

	task automatic run_phase(int count, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct <= r_pct;
		repeat (count)
			send_pose(pick_pos(), pick_pos(), pick_heading(), pick_pos(), pick_pos(),
				pick_heading());
	endtask

	initial begin
		arst_n             <= 1'b0;
		item.valid         <= 1'b0;
		item.rel_x         <= '0;
		item.rel_y         <= '0;
		item.rel_heading   <= '0;
		item.robot_x       <= '0;
		item.robot_y       <= '0;
		item.robot_heading <= '0;
		recv_idle_pct      <= 25;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed poses ---
		send_pose('0, '0, '0, '0, '0, '0);
		send_pose(24'sd1000, '0, '0, '0, '0, '0);
		// one per quadrant edge, and just either side of the fold
		send_pose(24'sd1000, 24'sd500, '0, 24'sd20, -24'sd30, DEG_90);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, DEG_180);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, DEG_270);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, DEG_90 - 16'd1);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, DEG_270 - 16'd1);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, DEG_180 - 16'd1);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, 16'hFFFF);
		send_pose(24'sd1000, 24'sd500, '0, '0, '0, DEG_45);
		// heading wrap past a full turn
		send_pose('0, '0, 16'hFFFF, '0, '0, 16'h0001);
		send_pose('0, '0, DEG_180, '0, '0, DEG_180);
		send_pose('0, '0, 16'hFFFF, '0, '0, 16'hFFFF);
		// on the rail without clipping, then one past it
		send_pose('0, '0, '0, POS_MAX, POS_MIN, '0);
		send_pose(24'sd1, -24'sd1, '0, POS_MAX, POS_MIN, '0);
		// clipping high on x, low on y, and both at once
		send_pose(POS_MAX, '0, '0, POS_MAX, '0, '0);
		send_pose('0, POS_MIN, '0, '0, POS_MIN, '0);
		send_pose(POS_MAX, POS_MAX, '0, POS_MAX, POS_MAX, '0);
		send_pose(POS_MIN, POS_MIN, '0, POS_MIN, POS_MIN, DEG_180);
		// a diagonal on the extremes: y grows by root two and clips on its own
		send_pose(POS_MAX, POS_MAX, '0, '0, '0, DEG_45);
		send_pose(POS_MIN, POS_MAX, 16'h5555, '0, '0, DEG_270 + DEG_45);
		directed_sent = poses_sent;
		hold_until_drained();

		// --- random poses, three idling regimes ---
		run_phase(PHASE_POSES, 17, 62);
		hold_until_drained();
		run_phase(PHASE_POSES, 62, 17);
		hold_until_drained();
		run_phase(RANDOM_POSES - 2 * PHASE_POSES, 0, 0);
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d poses offered (%0d directed), %0d world poses checked, %0d clipped.",
			poses_sent, directed_sent, poses_checked, clipped_seen);
		$display("Idling: sender-light/receiver-heavy, the reverse, then back-to-back; %0d mismatches.",
			mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
